### rtl/pic12bit_microcontroller_core_defines.svh
// Assertion macros shared by the checker.
`ifndef PIC12BIT_MICROCONTROLLER_CORE_DEFINES_SVH
`define PIC12BIT_MICROCONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PIC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define PIC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pic12_pkg.sv
package pic12_pkg;

  localparam int unsigned PROG_WORDS = 512;
  localparam int unsigned PROG_AW    = $clog2(PROG_WORDS);
  localparam int unsigned FILE_REGS  = 32;
  localparam int unsigned FILE_AW    = $clog2(FILE_REGS);

  // Commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;
  localparam logic [1:0] CMD_RTCC  = 2'd3;

  // Literal and control group, op[11:8]
  localparam logic [3:0] LIT_RETLW = 4'h8;
  localparam logic [3:0] LIT_CALL  = 4'h9;
  localparam logic [3:0] LIT_GOTO0 = 4'hA;
  localparam logic [3:0] LIT_GOTO1 = 4'hB;
  localparam logic [3:0] LIT_MOVLW = 4'hC;
  localparam logic [3:0] LIT_IORLW = 4'hD;
  localparam logic [3:0] LIT_ANDLW = 4'hE;
  localparam logic [3:0] LIT_XORLW = 4'hF;

  // Bit group, op[9:8]
  localparam logic [1:0] BIT_BCF   = 2'd0;
  localparam logic [1:0] BIT_BSF   = 2'd1;
  localparam logic [1:0] BIT_BTFSC = 2'd2;
  localparam logic [1:0] BIT_BTFSS = 2'd3;

  // Byte-oriented file group, op[9:6]
  localparam logic [3:0] ALU_MOVWF  = 4'h0;
  localparam logic [3:0] ALU_CLR    = 4'h1;
  localparam logic [3:0] ALU_SUBWF  = 4'h2;
  localparam logic [3:0] ALU_DECF   = 4'h3;
  localparam logic [3:0] ALU_IORWF  = 4'h4;
  localparam logic [3:0] ALU_ANDWF  = 4'h5;
  localparam logic [3:0] ALU_XORWF  = 4'h6;
  localparam logic [3:0] ALU_ADDWF  = 4'h7;
  localparam logic [3:0] ALU_MOVF   = 4'h8;
  localparam logic [3:0] ALU_COMF   = 4'h9;
  localparam logic [3:0] ALU_INCF   = 4'hA;
  localparam logic [3:0] ALU_DECFSZ = 4'hB;
  localparam logic [3:0] ALU_RRF    = 4'hC;
  localparam logic [3:0] ALU_RLF    = 4'hD;
  localparam logic [3:0] ALU_SWAPF  = 4'hE;
  localparam logic [3:0] ALU_INCFSZ = 4'hF;

  // Special file addresses
  localparam logic [4:0] FA_INDF   = 5'd0;
  localparam logic [4:0] FA_TMR0   = 5'd1;
  localparam logic [4:0] FA_PCL    = 5'd2;
  localparam logic [4:0] FA_STATUS = 5'd3;
  localparam logic [4:0] FA_FSR    = 5'd4;
  localparam logic [4:0] FA_PORTA  = 5'd5;
  localparam logic [4:0] FA_PORTB  = 5'd6;

  localparam logic [7:0]  STATUS_RESET = 8'h98;
  localparam logic [7:0]  STATUS_FIXED = 8'h80;
  localparam logic [11:0] PROG_BLANK   = 12'hFFF;

endpackage

### rtl/pic12bit_microcontroller_core.sv
// Channel   Signals                              Direction  Transfer
// input     in_valid_i / in_ready_o + fields     in         valid & ready
// output    out_valid_o / out_ready_i + fields   out        valid & ready
// config    cfg_we_i, cfg_wdata_i (program mask) in         write enable
//
// For every command the program store is read at the accept edge, the file
// register memory in the next cycle, and the update commits in the execute
// state while the next item may be accepted.
// After reset a clearing pass fills the 512-word program store with 0xFFF,
// holding in_ready_o low until the pass is done.
// A result waiting in the output register stalls commit, and with it the
// next input transfer, until the result is taken.
module pic12bit_microcontroller_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [8:0]                   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   command_i,
  input  logic [pic12_pkg::PROG_AW-1:0] program_address_i,
  input  logic [11:0]                  program_word_i,
  input  logic                         rtcc_pin_i,
  input  logic [3:0]                   port_a_pins_i,
  input  logic [7:0]                   port_b_pins_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [8:0]                   program_counter_o,
  output logic [7:0]                   working_reg_o,
  output logic [7:0]                   status_reg_o,
  output logic [7:0]                   timer_count_o,
  output logic [3:0]                   port_a_latch_o,
  output logic                         port_a_strobe_o,
  output logic [7:0]                   port_b_latch_o,
  output logic                         port_b_strobe_o,
  output logic [1:0]                   cycles_used_o
);
  import pic12_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EX   = 2'd2;

  logic [1:0] state_q, state_d;
  logic [PROG_AW:0] clr_cnt_q;
  logic clearing, in_xfer, commit;
  logic out_valid_q;

  // Architectural state
  logic [8:0] mask_q, pc_q, pc_d, stk0_q, stk0_d, stk1_q, stk1_d;
  logic [7:0] w_q, w_d, st_q, st_d, tmr_q, tmr_d, pb_q, pb_d;
  logic [4:0] fsr_q, fsr_d;
  logic [3:0] pa_q, pa_d;
  logic       rtcc_q, rtcc_d;
  logic [FILE_REGS-1:0] fvalid_q;

  // Latched item
  logic [1:0] cmd_q;
  logic       pin_q;
  logic [3:0] pins_a_q;
  logic [7:0] pins_b_q;

  // Memories
  logic [11:0] prog_mem [PROG_WORDS];
  logic [11:0] prog_rdata_q;
  logic [7:0]  file_mem [FILE_REGS];
  logic [7:0]  file_rdata_q;
  logic        file_rvalid_q;
  logic [PROG_AW-1:0] fetch_addr;

  // Execute datapath
  logic [11:0] op;
  logic [4:0]  eff;
  logic [7:0]  fv, r, wr_val, bsel;
  logic [8:0]  pcn, sum9;
  logic        wr_en, skip, pcl_hit, fw_en, fclr, sa, sb;
  logic        c_en, c_val, dc_en, dc_val, z_en, z_val;
  logic [1:0]  cost;

  assign clearing = (clr_cnt_q < (PROG_AW+1)'(PROG_WORDS));
  assign commit   = (state_q == ST_EX) && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clearing && ((state_q == ST_IDLE) || commit);
  assign in_xfer  = in_valid_i && in_ready_o;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_RD;
      ST_RD:   state_d = ST_EX;
      ST_EX:   if (in_xfer) state_d = ST_RD; else if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      clr_cnt_q <= '0;
      mask_q    <= 9'h1FF;
    end else begin
      state_q <= state_d;
      if (clearing) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cfg_we_i) mask_q <= cfg_wdata_i;
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q    <= command_i;
      pin_q    <= rtcc_pin_i;
      pins_a_q <= port_a_pins_i;
      pins_b_q <= port_b_pins_i;
    end
  end

  // Program store: clearing pass, loads, fetch at accept
  assign fetch_addr = PROG_AW'(pc_d & mask_q);

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      prog_mem[clr_cnt_q[PROG_AW-1:0]] <= PROG_BLANK;
    end else if (in_xfer && command_i == CMD_LOAD) begin
      prog_mem[program_address_i] <= program_word_i;
    end
    if (in_xfer) prog_rdata_q <= prog_mem[fetch_addr];
  end

  assign op  = prog_rdata_q;
  assign eff = (op[4:0] == FA_INDF) ? fsr_q : op[4:0];

  // File register memory: read in RD, write at commit
  always_ff @(posedge clk_i) begin
    if (fw_en) file_mem[eff] <= wr_val;
    if (state_q == ST_RD) file_rdata_q <= file_mem[eff];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvalid_q      <= '0;
      file_rvalid_q <= 1'b0;
    end else begin
      if (state_q == ST_RD) file_rvalid_q <= fvalid_q[eff];
      if (fclr) fvalid_q <= '0;
      else if (fw_en) fvalid_q[eff] <= 1'b1;
    end
  end

  assign pcn  = (pc_q + 9'd1) & mask_q;
  assign bsel = 8'd1 << op[7:5];

  // File read view
  always_comb begin
    case (eff)
      FA_INDF:   fv = 8'h00;
      FA_TMR0:   fv = tmr_q;
      FA_PCL:    fv = pcn[7:0];
      FA_STATUS: fv = st_q;
      FA_FSR:    fv = {3'b111, fsr_q};
      FA_PORTA:  fv = {4'h0, pins_a_q & pa_q};
      FA_PORTB:  fv = pins_b_q & pb_q;
      default:   fv = file_rvalid_q ? file_rdata_q : 8'h00;
    endcase
  end

  // Instruction execute and command update
  always_comb begin
    pc_d = pc_q; w_d = w_q; st_d = st_q; fsr_d = fsr_q; tmr_d = tmr_q;
    pa_d = pa_q; pb_d = pb_q; stk0_d = stk0_q; stk1_d = stk1_q; rtcc_d = rtcc_q;
    r = 8'h00; wr_en = 1'b0; wr_val = 8'h00; skip = 1'b0; pcl_hit = 1'b0;
    fw_en = 1'b0; fclr = 1'b0; sa = 1'b0; sb = 1'b0; cost = 2'd0;
    c_en = 1'b0; c_val = 1'b0; dc_en = 1'b0; dc_val = 1'b0; z_en = 1'b0; z_val = 1'b0;
    sum9 = {1'b0, fv} + {1'b0, w_q};

    if (state_q == ST_EX) begin
      unique case (cmd_q)
        CMD_LOAD: ;
        CMD_RESET: begin
          w_d = 8'h00; st_d = STATUS_RESET; fsr_d = 5'd0; tmr_d = 8'h00;
          pa_d = 4'h0; pb_d = 8'h00; stk0_d = 9'd0; stk1_d = 9'd0;
          rtcc_d = 1'b1; pc_d = mask_q; fclr = commit;
        end
        CMD_RTCC: begin
          if (rtcc_q && !pin_q) tmr_d = tmr_q + 8'd1;
          rtcc_d = pin_q;
        end
        CMD_EXEC: begin
          pc_d = pcn;
          cost = 2'd1;
          if (op[11]) begin
            case (op[11:8])
              LIT_RETLW: begin
                pc_d = stk1_q & mask_q; stk1_d = stk0_q; w_d = op[7:0]; cost = 2'd2;
              end
              LIT_CALL: begin
                stk0_d = stk1_q; stk1_d = pcn; pc_d = {1'b0, op[7:0]} & mask_q;
                cost = 2'd2;
              end
              LIT_GOTO0, LIT_GOTO1: begin
                pc_d = op[8:0] & mask_q; cost = 2'd2;
              end
              LIT_MOVLW: w_d = op[7:0];
              LIT_IORLW: begin
                w_d = w_q | op[7:0]; z_en = 1'b1; z_val = (w_d == 8'h00);
              end
              LIT_ANDLW: begin
                w_d = w_q & op[7:0]; z_en = 1'b1; z_val = (w_d == 8'h00);
              end
              default: begin
                w_d = w_q ^ op[7:0]; z_en = 1'b1; z_val = (w_d == 8'h00);
              end
            endcase
          end else if (op[10]) begin
            case (op[9:8])
              BIT_BCF: begin wr_en = 1'b1; wr_val = fv & ~bsel; end
              BIT_BSF: begin wr_en = 1'b1; wr_val = fv | bsel; end
              BIT_BTFSC: skip = ((fv & bsel) == 8'h00);
              default:   skip = ((fv & bsel) != 8'h00);
            endcase
          end else begin
            case (op[9:6])
              ALU_MOVWF: begin wr_en = op[5]; wr_val = w_q; end
              ALU_CLR: begin
                wr_en = op[5]; wr_val = 8'h00;
                if (!op[5]) w_d = 8'h00;
                z_en = 1'b1; z_val = 1'b1;
              end
              default: begin
                case (op[9:6])
                  ALU_SUBWF:  r = fv - w_q;
                  ALU_DECF, ALU_DECFSZ: r = fv - 8'd1;
                  ALU_IORWF:  r = fv | w_q;
                  ALU_ANDWF:  r = fv & w_q;
                  ALU_XORWF:  r = fv ^ w_q;
                  ALU_ADDWF:  r = sum9[7:0];
                  ALU_MOVF:   r = fv;
                  ALU_COMF:   r = ~fv;
                  ALU_RRF:    r = {st_q[0], fv[7:1]};
                  ALU_RLF:    r = {fv[6:0], st_q[0]};
                  ALU_SWAPF:  r = {fv[3:0], fv[7:4]};
                  default:    r = fv + 8'd1;
                endcase
                wr_en = op[5]; wr_val = r;
                if (!op[5]) w_d = r;
                case (op[9:6])
                  ALU_SUBWF: begin
                    c_en = 1'b1; c_val = (fv >= w_q);
                    dc_en = 1'b1; dc_val = (fv[3:0] >= w_q[3:0]);
                    z_en = 1'b1; z_val = (r == 8'h00);
                  end
                  ALU_ADDWF: begin
                    c_en = 1'b1; c_val = sum9[8];
                    dc_en = 1'b1; dc_val = (fv[3:0] > r[3:0]);
                    z_en = 1'b1; z_val = (r == 8'h00);
                  end
                  ALU_DECFSZ, ALU_INCFSZ: skip = (r == 8'h00);
                  ALU_RRF: begin c_en = 1'b1; c_val = fv[0]; end
                  ALU_RLF: begin c_en = 1'b1; c_val = fv[7]; end
                  ALU_SWAPF: ;
                  default: begin z_en = 1'b1; z_val = (r == 8'h00); end
                endcase
              end
            endcase
          end

          // File write
          if (wr_en) begin
            case (eff)
              FA_INDF:   ;
              FA_TMR0:   tmr_d = wr_val;
              FA_PCL:    begin pc_d = {1'b0, wr_val} & mask_q; pcl_hit = 1'b1; end
              FA_STATUS: st_d = wr_val | STATUS_FIXED;
              FA_FSR:    fsr_d = wr_val[4:0];
              FA_PORTA:  begin pa_d = wr_val[3:0]; sa = 1'b1; end
              FA_PORTB:  begin pb_d = wr_val; sb = 1'b1; end
              default:   fw_en = commit;
            endcase
          end

          // Flags land after any STATUS write
          if (c_en)  st_d[0] = c_val;
          if (dc_en) st_d[1] = dc_val;
          if (z_en)  st_d[2] = z_val;

          if (skip) begin
            pc_d = (pc_d + 9'd1) & mask_q;
            cost = 2'd2;
          end
          if (pcl_hit) cost = cost + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= 9'h1FF; w_q <= 8'h00; st_q <= STATUS_RESET; fsr_q <= 5'd0;
      tmr_q <= 8'h00; pa_q <= 4'h0; pb_q <= 8'h00; stk0_q <= 9'd0; stk1_q <= 9'd0;
      rtcc_q <= 1'b1; out_valid_o <= 1'b0;
    end else begin
      if (commit) begin
        pc_q <= pc_d; w_q <= w_d; st_q <= st_d; fsr_q <= fsr_d; tmr_q <= tmr_d;
        pa_q <= pa_d; pb_q <= pb_d; stk0_q <= stk0_d; stk1_q <= stk1_d;
        rtcc_q <= rtcc_d;
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assign out_valid_q = out_valid_o;

  always_ff @(posedge clk_i) begin
    if (commit) begin
      program_counter_o <= pc_d;
      working_reg_o     <= w_d;
      status_reg_o      <= st_d;
      timer_count_o     <= tmr_d;
      port_a_latch_o    <= pa_d;
      port_a_strobe_o   <= sa;
      port_b_latch_o    <= pb_d;
      port_b_strobe_o   <= sb;
      cycles_used_o     <= cost;
    end
  end

endmodule

### rtl/pic12_chk.sv
`include "pic12bit_microcontroller_core_defines.svh"

module pic12_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [8:0]                    cfg_wdata_i,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [1:0]                    command_i,
  input logic [pic12_pkg::PROG_AW-1:0] program_address_i,
  input logic [11:0]                   program_word_i,
  input logic                          rtcc_pin_i,
  input logic [3:0]                    port_a_pins_i,
  input logic [7:0]                    port_b_pins_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [8:0]                    program_counter_o,
  input logic [7:0]                    working_reg_o,
  input logic [7:0]                    status_reg_o,
  input logic [7:0]                    timer_count_o,
  input logic [3:0]                    port_a_latch_o,
  input logic                          port_a_strobe_o,
  input logic [7:0]                    port_b_latch_o,
  input logic                          port_b_strobe_o,
  input logic [1:0]                    cycles_used_o
);

  // Stalled result must not change its program counter or status
  `PIC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(program_counter_o) && $stable(status_reg_o), "result changed while stalled")

  // STATUS bit 7 always reads as one
  `PIC_ASSERT_IMP(a_status_fixed, clk_i, rst_ni, out_valid_o, status_reg_o[7], "status bit 7 low")

  // Every item passes through the file read stage, so ready drops after a transfer
  `PIC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready right after transfer")

  // Non-execute commands never strobe the ports
  `PIC_ASSERT_IMP(a_strobe_exec, clk_i, rst_ni, out_valid_o && (cycles_used_o == 2'd0), !port_a_strobe_o && !port_b_strobe_o, "strobe without execute")

endmodule

bind pic12bit_microcontroller_core pic12_chk u_pic12_chk (.*);
